### rtl/sirs_pkg.sv
// Package for the signed integer to radix symbol converter.
// Holds field widths, character codes, register indexes and the alphabet helpers.
// No dependencies.
package sirs_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 16;
	localparam int unsigned VALUE_BITS_DEF  = 32;

	localparam int unsigned RADIX_W   = 5;
	localparam int unsigned CMP_W     = RADIX_W + 1;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned ALPHA_N   = 16;
	localparam int unsigned SYM_IDX_W = 4;
	localparam int unsigned SYMS_W    = ALPHA_N * CHAR_W;
	localparam int unsigned STEP_BITS = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
	localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX        = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic ok;
		logic neg;
	} class_t;

	function automatic logic [CHAR_W-1:0] sym_at(logic [SYMS_W-1:0] syms,
			logic [SYM_IDX_W-1:0] idx);
		return syms[{idx, 3'b000} +: CHAR_W];
	endfunction

	function automatic logic alphabet_good(logic [RADIX_W-1:0] radix,
			logic [SYMS_W-1:0] syms, int unsigned max_sym);
		logic good;
		logic [CHAR_W-1:0] s;
		good = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(max_sym));
		for (int i = 0; i < ALPHA_N; i++) begin
			s = syms[i*CHAR_W +: CHAR_W];
			if (RADIX_W'(i) < radix) begin
				if (s == NUL_CHAR || s == MINUS_CHAR || s == PLUS_CHAR)
					good = 1'b0;
				for (int j = i + 1; j < ALPHA_N; j++) begin
					if (RADIX_W'(j) < radix && syms[j*CHAR_W +: CHAR_W] == s)
						good = 1'b0;
				end
			end
		end
		return good;
	endfunction

endpackage

### rtl/sirs_front.sv
// Front stage: accepts values, forms sign and magnitude, checks the alphabet.
// Depends on sirs_pkg.
module sirs_front import sirs_pkg::*; #(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]           radix,
	input  logic [SYMS_W-1:0]            symbols,
	input  logic                         q_full,
	output logic                         q_push,
	output class_t                       q_class,
	output logic [VALUE_BITS-1:0]        q_mag
);

	logic                  valid_s1;
	logic                  neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic [VALUE_BITS-1:0] uval;
	logic                  accept;

	assign uval    = value;
	assign full    = valid_s1 && q_full;
	assign accept  = push && !full;
	assign q_push  = valid_s1 && !q_full;
	assign q_mag   = mag_s1;
	assign q_class = '{ok: alphabet_good(radix, symbols, MAX_SYMBOLS), neg: neg_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= uval[VALUE_BITS-1];
			mag_s1 <= uval[VALUE_BITS-1] ? (~uval + VALUE_BITS'(1)) : uval;
		end
	end

endmodule

### rtl/sirs_queue.sv
// Short queue between the front stage and the conversion engine.
// Depends on sirs_pkg for the default depth.
module sirs_queue import sirs_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### rtl/sirs_back.sv
// Conversion engine: digit-by-digit long division, digit store, symbol emission.
// Depends on sirs_pkg.
module sirs_back import sirs_pkg::*; #(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [RADIX_W-1:0]    radix,
	input  logic [SYMS_W-1:0]     symbols,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  class_t                q_class,
	input  logic [VALUE_BITS-1:0] q_mag,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     symbol,
	output logic                  is_last,
	output logic                  alphabet_ok
);

	localparam int unsigned DIGIT_W    = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int unsigned IDX_W      = $clog2(VALUE_BITS);
	localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int unsigned STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int unsigned PAD_BITS   = STEPS * STEP_BITS;
	localparam int unsigned STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SIGN = 6'b000100,
		ST_RD   = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_BAD  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [PAD_BITS-1:0]     w_q;
	logic [DIGIT_W-1:0]      rem_q;
	logic [STEP_CNT_W-1:0]   step_q;
	logic [CNT_W-1:0]        dcnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    neg_q;
	logic [DIGIT_W-1:0]      mem_q [VALUE_BITS];
	logic [DIGIT_W-1:0]      rd_data_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       symbol_q;
	logic                    last_q;
	logic                    ok_q;

	logic [STEP_BITS-1:0]    chunk;
	logic [STEP_BITS-1:0]    qbits;
	logic [DIGIT_W-1:0]      r_next;
	logic [CMP_W-1:0]        t;
	logic [PAD_BITS-1:0]     w_next;
	logic                    digit_done;
	logic                    conv_done;
	logic                    out_free;
	logic                    out_load;
	logic [CHAR_W-1:0]       out_sym;
	logic                    out_last;
	logic                    out_ok;
	logic                    wr_en;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;

	assign empty       = !out_valid_q;
	assign symbol      = symbol_q;
	assign is_last     = last_q;
	assign alphabet_ok = ok_q;
	assign out_free    = !out_valid_q || pop;
	assign q_pop       = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		chunk  = w_q[PAD_BITS-1 -: STEP_BITS];
		qbits  = '0;
		r_next = rem_q;
		t      = '0;
		for (int b = STEP_BITS - 1; b >= 0; b--) begin
			t = CMP_W'({r_next, chunk[b]});
			if (t >= CMP_W'(radix)) begin
				qbits[b] = 1'b1;
				t        = t - CMP_W'(radix);
			end
			r_next = t[DIGIT_W-1:0];
		end
		w_next     = (w_q << STEP_BITS) | PAD_BITS'(qbits);
		digit_done = (step_q == STEP_CNT_W'(STEPS - 1));
		conv_done  = (w_next == '0) || (dcnt_q == CNT_W'(VALUE_BITS - 1));
	end

	always_comb begin
		out_load = 1'b0;
		out_sym  = NUL_CHAR;
		out_last = 1'b0;
		out_ok   = 1'b1;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_DIV: begin
				wr_en = digit_done;
			end
			ST_SIGN: begin
				out_load = out_free;
				out_sym  = MINUS_CHAR;
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_EMIT: begin
				out_load = out_free;
				out_sym  = sym_at(symbols, SYM_IDX_W'(rd_data_q));
				out_last = (idx_q == '0);
				rd_en    = out_free && (idx_q != '0);
				rd_addr  = idx_q - IDX_W'(1);
			end
			ST_BAD: begin
				out_load = out_free;
				out_last = 1'b1;
				out_ok   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			w_q         <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			dcnt_q      <= '0;
			idx_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						neg_q  <= q_class.neg;
						w_q    <= PAD_BITS'(q_mag);
						rem_q  <= '0;
						step_q <= '0;
						dcnt_q <= '0;
						state_q <= q_class.ok ? ST_DIV : ST_BAD;
					end
				end
				ST_DIV: begin
					w_q <= w_next;
					if (!digit_done) begin
						rem_q  <= r_next;
						step_q <= step_q + STEP_CNT_W'(1);
					end else begin
						rem_q  <= '0;
						step_q <= '0;
						dcnt_q <= dcnt_q + CNT_W'(1);
						if (conv_done) begin
							idx_q   <= dcnt_q[IDX_W-1:0];
							state_q <= neg_q ? ST_SIGN : ST_RD;
						end
					end
				end
				ST_SIGN: begin
					if (out_free)
						state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == '0)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_BAD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[dcnt_q[IDX_W-1:0]] <= r_next;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			symbol_q <= out_sym;
			last_q   <= out_last;
			ok_q     <= out_ok;
		end
	end

endmodule

### rtl/signed_int_to_radix_symbols.sv
// Top level of the signed integer to radix symbol converter: configuration
// registers, front stage, queue and conversion engine. Depends on sirs_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  input    | push / full              | value
//  result   | empty / pop              | symbol, is_last, alphabet_ok
//  config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// The long-division loop forms each digit in 8-bit steps over the padded magnitude (8 quotient
// bits per cycle); a negative value also gets a leading minus sign.
// A bad alphabet gives one result. No clearing pass after reset.
// The front stage and a two-entry queue keep taking values while the engine works.
// A stalled result holds the engine once it has a symbol to emit; cfg_ready is always high.
module signed_int_to_radix_symbols import sirs_pkg::*; #(
	parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         empty,
	input  logic                         pop,
	output logic [CHAR_W-1:0]            symbol,
	output logic                         is_last,
	output logic                         alphabet_ok,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam int unsigned Q_W = $bits(class_t) + VALUE_BITS;

	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_W-1:0]      sym_lo_q;
	logic [CFG_W-1:0]      sym_hi_q;
	logic [SYMS_W-1:0]     symbols;
	logic                  f_push;
	logic                  f_full;
	class_t                f_class;
	logic [VALUE_BITS-1:0] f_mag;
	logic                  b_pop;
	logic                  b_empty;
	logic [Q_W-1:0]        b_data;
	class_t                b_class;
	logic [VALUE_BITS-1:0] b_mag;

	assign cfg_ready = 1'b1;
	assign symbols   = {sym_hi_q, sym_lo_q};
	assign b_class   = b_data[Q_W-1 -: $bits(class_t)];
	assign b_mag     = b_data[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX:        radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sirs_front #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.VALUE_BITS  (VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.value   (value),
		.radix   (radix_q),
		.symbols (symbols),
		.q_full  (f_full),
		.q_push  (f_push),
		.q_class (f_class),
		.q_mag   (f_mag)
	);

	sirs_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.wdata  ({f_class, f_mag}),
		.pop    (b_pop),
		.empty  (b_empty),
		.rdata  (b_data)
	);

	sirs_back #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.VALUE_BITS  (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix       (radix_q),
		.symbols     (symbols),
		.q_empty     (b_empty),
		.q_pop       (b_pop),
		.q_class     (b_class),
		.q_mag       (b_mag),
		.empty       (empty),
		.pop         (pop),
		.symbol      (symbol),
		.is_last     (is_last),
		.alphabet_ok (alphabet_ok)
	);

endmodule

### rtl/sirs_checker.sv
// Port-level checks on the result channel of the radix symbol converter.
// Depends on sirs_pkg; bound to the top level at the end of this file.
module sirs_checker import sirs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [CHAR_W-1:0] symbol,
	input logic              is_last,
	input logic              alphabet_ok
);

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !alphabet_ok |-> is_last && symbol == NUL_CHAR)
		else $error("bad-alphabet result is not a single zero symbol");

	a_no_nul: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && alphabet_ok |-> symbol != NUL_CHAR)
		else $error("good result carries a zero byte");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && alphabet_ok && symbol == MINUS_CHAR |-> !is_last)
		else $error("sign closes a run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(symbol) && $stable(is_last)
			&& $stable(alphabet_ok))
		else $error("stalled result changed");

endmodule

bind signed_int_to_radix_symbols sirs_checker u_sirs_checker (.*);
